>>> hw/rtl/dssw_pkg.sv
`timescale 1ns / 1ps

package dssw_pkg;

    localparam int MAX_DIGITS_DEFAULT = 8;
    localparam int VALUE_W            = 32;
    localparam int BITS_PER_STEP      = 4;
    localparam int CONV_STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W             = $clog2(CONV_STEPS);
    localparam int COUNT_W            = 4;
    localparam int POS_W              = 3;
    localparam int ADDR_W             = 4;
    localparam int SEG_W              = 7;

    localparam logic [SEG_W-1:0] SEG_0 = 7'h7E;
    localparam logic [SEG_W-1:0] SEG_1 = 7'h30;
    localparam logic [SEG_W-1:0] SEG_2 = 7'h6D;
    localparam logic [SEG_W-1:0] SEG_3 = 7'h79;
    localparam logic [SEG_W-1:0] SEG_4 = 7'h33;
    localparam logic [SEG_W-1:0] SEG_5 = 7'h5B;
    localparam logic [SEG_W-1:0] SEG_6 = 7'h5F;
    localparam logic [SEG_W-1:0] SEG_7 = 7'h70;
    localparam logic [SEG_W-1:0] SEG_8 = 7'h7F;
    localparam logic [SEG_W-1:0] SEG_9 = 7'h7B;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
        logic [POS_W-1:0]   start_position;
    } num_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] reg_address;
        logic [SEG_W-1:0]  seg_data;
        logic              last;
    } wr_item_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = SEG_0;
            4'd1:    seg = SEG_1;
            4'd2:    seg = SEG_2;
            4'd3:    seg = SEG_3;
            4'd4:    seg = SEG_4;
            4'd5:    seg = SEG_5;
            4'd6:    seg = SEG_6;
            4'd7:    seg = SEG_7;
            4'd8:    seg = SEG_8;
            4'd9:    seg = SEG_9;
            default: seg = SEG_0;
        endcase
        return seg;
    endfunction

endpackage

>>> hw/rtl/dssw_queue.sv
`timescale 1ns / 1ps

module dssw_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [1:0][WIDTH-1:0] mem_reg;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_ptr_even: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/dssw_front.sv
`timescale 1ns / 1ps

module dssw_front #(
    parameter int MAX_DIGITS = dssw_pkg::MAX_DIGITS_DEFAULT,
    parameter int ENTRY_W    = 4 * MAX_DIGITS + 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  dssw_pkg::num_item_t num,
    output logic                q_valid,
    input  logic                q_ready,
    output logic [ENTRY_W-1:0]  q_data
);

    import dssw_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t        state_reg;
    front_state_t        state_next;
    logic [VALUE_W-1:0]  val_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [COUNT_W-1:0]  n_reg;
    logic [POS_W-1:0]    start_reg;
    logic [COUNT_W-1:0]  writes_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COUNT_W-1:0]  n_sat;
    logic [COUNT_W-1:0]  span;
    logic [COUNT_W-1:0]  writes_in;
    logic                accept;

    assign num_ready = (state_reg == F_IDLE);
    assign accept    = num_valid && num_ready;
    assign q_valid   = (state_reg == F_PUSH);
    assign q_data    = {bcd_reg, start_reg, n_reg, writes_reg};

    assign n_sat     = (num.digit_count > COUNT_W'(MAX_DIGITS)) ?
                       COUNT_W'(MAX_DIGITS) : num.digit_count;
    assign span      = {1'b0, num.start_position} + COUNT_W'(1);
    assign writes_in = (n_sat > span) ? span : n_sat;

    // Shift-and-add-3 conversion, four value bits per cycle, most significant first.
    always_comb
    begin
        bcd_next = bcd_reg;
        for (int j = 0; j < BITS_PER_STEP; j++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (bcd_next[d*4 +: 4] >= 4'd5)
                begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            if (BCD_W > 1)
            begin
                bcd_next = {bcd_next[BCD_W-2:0], val_reg[VALUE_W-1-j]};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && (n_sat != '0))
                begin
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == F_CONV)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg    <= num.value;
            bcd_reg    <= '0;
            n_reg      <= n_sat;
            start_reg  <= num.start_position;
            writes_reg <= writes_in;
        end
        else if (state_reg == F_CONV)
        begin
            val_reg <= val_reg << BITS_PER_STEP;
            bcd_reg <= bcd_next;
        end
    end

`ifndef SYNTHESIS
    a_zero_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (n_sat == '0)) |=> (state_reg == F_IDLE))
        else $error("zero digit count item was not dropped");
    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CONV && step_reg == STEP_W'(CONV_STEPS - 1)) |=>
        (state_reg == F_PUSH))
        else $error("conversion did not end after its last step");
    a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (writes_reg != '0 && n_reg != '0 && writes_reg <= n_reg))
        else $error("queued entry has an inconsistent write count");
`endif

endmodule

>>> hw/rtl/dssw_back.sv
`timescale 1ns / 1ps

module dssw_back #(
    parameter int MAX_DIGITS = dssw_pkg::MAX_DIGITS_DEFAULT,
    parameter int ENTRY_W    = 4 * MAX_DIGITS + 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               wr_valid,
    input  logic               wr_ready,
    output dssw_pkg::wr_item_t wr
);

    import dssw_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EMIT = 2'b10
    } back_state_t;

    back_state_t                 state_reg;
    logic [MAX_DIGITS-1:0][3:0]  bcd_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic [COUNT_W-1:0]          rem_reg;
    logic                        out_valid_reg;
    wr_item_t                    out_reg;
    logic [MAX_DIGITS-1:0][3:0]  q_bcd;
    logic [POS_W-1:0]            q_start;
    logic [COUNT_W-1:0]          q_n;
    logic [COUNT_W-1:0]          q_writes;
    logic                        slot_free;
    logic                        emit;

    assign q_bcd    = q_data[ENTRY_W-1 -: 4*MAX_DIGITS];
    assign q_start  = q_data[2*COUNT_W +: POS_W];
    assign q_n      = q_data[COUNT_W +: COUNT_W];
    assign q_writes = q_data[COUNT_W-1:0];

    assign q_ready   = (state_reg == B_IDLE);
    assign slot_free = !out_valid_reg || wr_ready;
    assign emit      = (state_reg == B_EMIT) && slot_free;
    assign wr_valid  = out_valid_reg;
    assign wr        = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wr_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        rem_reg   <= q_writes;
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT:
                begin
                    if (emit)
                    begin
                        rem_reg <= rem_reg - COUNT_W'(1);
                        if (rem_reg == COUNT_W'(1))
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            bcd_reg  <= q_bcd;
            idx_reg  <= IDX_W'(q_n - COUNT_W'(1));
            addr_reg <= {1'b0, q_start} + ADDR_W'(1);
        end
        else if (emit)
        begin
            idx_reg  <= idx_reg - IDX_W'(1);
            addr_reg <= addr_reg - ADDR_W'(1);
        end
        if (emit)
        begin
            out_reg.reg_address <= addr_reg;
            out_reg.seg_data    <= seg_of(bcd_reg[idx_reg]);
            out_reg.last        <= (rem_reg == COUNT_W'(1));
        end
    end

`ifndef SYNTHESIS
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (rem_reg != '0))
        else $error("emitting with no writes left");
    a_addr_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (addr_reg != '0))
        else $error("register address fell below the first digit");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && rem_reg == COUNT_W'(1)) |=> (wr_valid && wr.last))
        else $error("final write of a run is not flagged");
    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && rem_reg != COUNT_W'(1)) |=> (wr_valid && !wr.last))
        else $error("write flagged last before the run ended");
`endif

endmodule

>>> hw/rtl/decimal_seven_segment_writer_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload       Handshake
// num       in         num_item_t    num_valid / num_ready
// wr        out        wr_item_t     wr_valid / wr_ready
//
// An item with a nonzero digit count holds the front through its acceptance, eight
// conversion steps of four bits each, and its push into the queue.
// The back fetches an entry, then makes one register write per cycle unless wr stalls.
// A zero digit count item is accepted and produces no beat.
// Reset clears all control state at once; there is no clearing pass.
// A two-entry queue separates conversion from output, so a stalled wr channel
// holds the front only once the queue is full.

module decimal_seven_segment_writer_top #(
    parameter int MAX_DIGITS = dssw_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  dssw_pkg::num_item_t num,
    output logic                wr_valid,
    input  logic                wr_ready,
    output dssw_pkg::wr_item_t  wr
);

    import dssw_pkg::*;

    localparam int ENTRY_W = 4 * MAX_DIGITS + POS_W + 2 * COUNT_W;

    logic               fq_valid;
    logic               fq_ready;
    logic [ENTRY_W-1:0] fq_data;
    logic               qb_valid;
    logic               qb_ready;
    logic [ENTRY_W-1:0] qb_data;

    dssw_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    dssw_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    dssw_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr       (wr)
    );

endmodule

>>> tb/sv/seg_write_checker.sv
`timescale 1ns / 1ps

module seg_write_checker #(
    parameter int MAX_DIGITS = dssw_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    input  logic                num_ready,
    input  dssw_pkg::num_item_t num,
    input  logic                wr_valid,
    input  logic                wr_ready,
    input  dssw_pkg::wr_item_t  wr,
    output int                  mismatches,
    output int                  writes_pending
);

    import dssw_pkg::*;

    localparam logic [9:0][SEG_W-1:0] SEG_LUT = {
        SEG_9, SEG_8, SEG_7, SEG_6, SEG_5, SEG_4, SEG_3, SEG_2, SEG_1, SEG_0
    };

    wr_item_t digit_writes[$];
    int       reported = 0;

    task automatic queue_digit_writes(input num_item_t item);
        int unsigned     count;
        int unsigned     writes;
        int unsigned     idx;
        logic [31:0]     rest;
        logic [3:0]      digits [MAX_DIGITS];
        wr_item_t        w;
        count = item.digit_count;
        if (count > MAX_DIGITS)
        begin
            count = MAX_DIGITS;
        end
        rest = item.value;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            digits[i] = 4'(rest % 10);
            rest = rest / 10;
        end
        writes = count;
        if (writes > item.start_position + 1)
        begin
            writes = item.start_position + 1;
        end
        for (int k = 0; k < writes; k++)
        begin
            idx = count - 1 - k;
            w.reg_address = ADDR_W'(item.start_position - k + 1);
            w.seg_data = SEG_LUT[digits[idx]];
            w.last = (k == writes - 1);
            digit_writes.push_back(w);
        end
    endtask

    always @(posedge clk)
    begin
        wr_item_t want;
        if (rst_n)
        begin
            if (wr_valid && wr_ready)
            begin
                if (digit_writes.size() == 0)
                begin
                    if (reported < 10)
                    begin
                        $display("unexpected beat: addr %0d seg %h last %b",
                                 wr.reg_address, wr.seg_data, wr.last);
                    end
                    reported = reported + 1;
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = digit_writes.pop_front();
                    if (wr.reg_address !== want.reg_address
                        || wr.seg_data !== want.seg_data
                        || wr.last !== want.last)
                    begin
                        if (reported < 10)
                        begin
                            $display("mismatch: expected addr %0d seg %h last %b,",
                                     want.reg_address, want.seg_data, want.last,
                                     " got addr %0d seg %h last %b",
                                     wr.reg_address, wr.seg_data, wr.last);
                        end
                        reported = reported + 1;
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (num_valid && num_ready)
            begin
                queue_digit_writes(num);
            end
            writes_pending <= digit_writes.size();
        end
    end

endmodule

>>> tb/sv/decimal_seven_segment_writer_top_tb.sv
`timescale 1ns / 1ps

module decimal_seven_segment_writer_top_tb;

    import dssw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      num_valid = 1'b0;
    logic      num_ready;
    num_item_t num = '0;
    logic      wr_valid;
    logic      wr_ready = 1'b0;
    wr_item_t  wr;

    int        mismatches;
    int        writes_pending;
    int        cycle_count = 0;
    int        tx_idle_pct = 14;
    int        rx_idle_pct = 53;
    logic      hold_req = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;

    decimal_seven_segment_writer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr)
    );

    seg_write_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .num_valid      (num_valid),
        .num_ready      (num_ready),
        .num            (num),
        .wr_valid       (wr_valid),
        .wr_ready       (wr_ready),
        .wr             (wr),
        .mismatches     (mismatches),
        .writes_pending (writes_pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("decimal_seven_segment_writer_top_tb NOT OK");
            $finish;
        end
    end

    // The receiver normally stalls at random; once asked, it holds off for a long stretch.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            wr_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            wr_ready <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            wr_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_number(input logic [31:0] v, input logic [3:0] c, input logic [2:0] s);
        num_item_t item;
        item.value = v;
        item.digit_count = c;
        item.start_position = s;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            num_valid <= 1'b0;
            @(posedge clk);
        end
        num <= item;
        num_valid <= 1'b1;
        @(posedge clk);
        while (!num_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_phase(input int beats_wanted);
        int          sent;
        int          pick;
        logic [31:0] v;
        logic [3:0]  c;
        logic [2:0]  s;
        sent = 0;
        while (sent < beats_wanted)
        begin
            case ($urandom_range(0, 3))
                0: v = $urandom();
                1: v = $urandom_range(0, 99999999);
                2: v = $urandom_range(0, 999);
                default: v = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                c = 4'd0;
            end
            else if (pick < 12)
            begin
                c = 4'($urandom_range(9, 15));
            end
            else
            begin
                c = 4'($urandom_range(1, 8));
            end
            s = 3'($urandom_range(0, 7));
            send_number(v, c, s);
            if (c != 0)
            begin
                sent = sent + 1;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number(32'd0, 4'd8, 3'd7);
        send_number(32'hFFFF_FFFF, 4'd8, 3'd7);
        send_number(32'd1234567890, 4'd8, 3'd7);
        send_number(32'd98765432, 4'd8, 3'd7);
        send_number(32'd12, 4'd2, 3'd5);
        send_number(32'd7, 4'd1, 3'd0);
        send_number(32'd4567, 4'd3, 3'd2);
        send_number(32'd55555, 4'd4, 3'd6);
        send_number(32'd123456, 4'd5, 3'd4);
        send_number(32'd9999999, 4'd6, 3'd7);
        send_number(32'd31415926, 4'd7, 3'd6);
        send_number(32'd42, 4'd0, 3'd7);
        send_number(32'd87654321, 4'd9, 3'd7);
        send_number(32'hFFFF_FFFF, 4'd15, 3'd3);
        send_number(32'd87654321, 4'd8, 3'd0);
        send_number(32'd87654321, 4'd8, 3'd3);
        send_number(32'd905, 4'd5, 3'd1);
        send_number(32'hFFFF_FFFF, 4'd15, 3'd7);
        send_number(32'd0, 4'd0, 3'd0);

        send_random_phase(113);
        tx_idle_pct = 53;
        rx_idle_pct <= 14;
        send_random_phase(113);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
        send_random_phase(111);

        num_valid <= 1'b0;
        @(posedge clk);
        while (writes_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && writes_pending == 0)
        begin
            $display("decimal_seven_segment_writer_top_tb OK");
        end
        else
        begin
            $display("decimal_seven_segment_writer_top_tb NOT OK");
        end
        $finish;
    end

endmodule
